// ===== design/csv_field_tokenizer_defines.svh =====
// Assertion macros for the CSV field tokenizer.
// Taken in by the top level; no other dependencies.
`ifndef CSV_FIELD_TOKENIZER_DEFINES_SVH
`define CSV_FIELD_TOKENIZER_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define CSVFT_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define CSVFT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/csvft_pkg.sv =====
// Shared types, constants and helpers of the CSV field tokenizer.
// No dependencies; used by csvft_ctrl, csvft_datapath and the top level.
package csvft_pkg;

   localparam int SPACE_DEPTH_DEF = 16;
   localparam int MAX_FIELDS_DEF  = 256;

   localparam logic [7:0] DELIM_RESET = 8'd44;
   localparam logic [7:0] QUOTE_RESET = 8'd34;

   // configuration port: two 8-bit registers in 32-bit words at byte addresses 0 and 4
   localparam int CSR_AW = 3;
   localparam int CSR_DW = 32;
   localparam logic REG_DELIM = 1'b0;
   localparam logic REG_QUOTE = 1'b1;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       byte_valid;
      logic       field_end;
      logic [7:0] field_index;
      logic       space_overflow;
      logic       last_of_run;
   } rsp_type;

   // controller -> datapath
   typedef struct packed {
      logic accept;
      logic flush_step;
      logic char_emit;
   } ctl_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic slot_free;
      logic needs_flush;
      logic flush_last;
   } dp_stat_type;

   function automatic logic is_space(input logic [7:0] c);
      return (c inside {[8'd9:8'd13], 8'd32});
   endfunction

endpackage

// ===== design/csvft_req_if.sv =====
// Input channel of the CSV field tokenizer: one byte or a line end per item.
// No dependencies.
interface csvft_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_byte;
   logic       line_end;

   modport source (output valid, char_byte, line_end, input ready);
   modport sink   (input valid, char_byte, line_end, output ready);
endinterface

// ===== design/csvft_rsp_if.sv =====
// Result channel of the CSV field tokenizer: content bytes and field ends.
// No dependencies.
interface csvft_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       byte_valid;
   logic       field_end;
   logic [7:0] field_index;
   logic       space_overflow;
   logic       last_of_run;

   modport source (output valid, out_byte, byte_valid, field_end, field_index,
                   space_overflow, last_of_run, input ready);
   modport sink   (input valid, out_byte, byte_valid, field_end, field_index,
                   space_overflow, last_of_run, output ready);
endinterface

// ===== design/csvft_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module csvft_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic             re,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== design/csvft_ctrl.sv =====
// Sequencer of the CSV field tokenizer: takes items, walks whitespace flushes.
// Depends on csvft_pkg.
module csvft_ctrl
   import csvft_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  dp_stat_type stat,
   output ctl_cmd_type cmd
);

   typedef enum logic [1:0] {ST_IDLE, ST_FLUSH, ST_CHAR} state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = stat.slot_free;
            if (req_valid && stat.slot_free) begin
               cmd.accept = 1'b1;
               if (stat.needs_flush) begin
                  state_in = ST_FLUSH;
               end
            end
         end
         ST_FLUSH: begin
            if (stat.slot_free) begin
               cmd.flush_step = 1'b1;
               if (stat.flush_last) begin
                  state_in = ST_CHAR;
               end
            end
         end
         ST_CHAR: begin
            if (stat.slot_free) begin
               cmd.char_emit = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== design/csvft_datapath.sv =====
// Datapath of the CSV field tokenizer: quote and field state, whitespace
// buffer, output register. Depends on csvft_pkg and csvft_ram.
module csvft_datapath
   import csvft_pkg::*;
#(
   parameter int SPACE_DEPTH = SPACE_DEPTH_DEF,
   parameter int MAX_FIELDS  = MAX_FIELDS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic [7:0]  delimiter_char,
   input  logic [7:0]  quote_char,
   input  logic [7:0]  char_byte,
   input  logic        line_end,
   input  ctl_cmd_type cmd,
   output dp_stat_type stat,
   input  logic        rsp_ready,
   output logic        rsp_valid,
   output rsp_type     rsp
);

   localparam int CW  = $clog2(SPACE_DEPTH + 1);
   localparam int AW  = (SPACE_DEPTH > 1) ? $clog2(SPACE_DEPTH) : 1;
   localparam int CAP = (MAX_FIELDS - 1 > 255) ? 255 : MAX_FIELDS - 1;

   logic          in_quotes_ff, in_quotes_in;
   logic          pending_ff, pending_in;
   logic          seen_ff, seen_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic [7:0]    counter_ff, counter_in;
   logic          ovf_ff, ovf_in;
   logic [7:0]    hold_ff, hold_in;
   logic          valid_ff, valid_in;
   rsp_type       rsp_ff, rsp_in;

   logic          ram_we, ram_re;
   logic [AW-1:0] ram_raddr;
   logic [7:0]    ram_rdata;

   logic          lit_quote, toggle, quotes_eff, is_quote, is_delim, is_content, sp;
   logic [CW-1:0] idx_nxt;
   logic          slot_free;

   // item decode; a pending quote followed by a quote is one literal quote
   always_comb begin
      lit_quote  = pending_ff && (char_byte == quote_char);
      toggle     = pending_ff && !lit_quote;
      quotes_eff = in_quotes_ff ^ toggle;
      is_quote   = !lit_quote && (char_byte == quote_char);
      is_delim   = !is_quote && !lit_quote && (char_byte == delimiter_char) && !quotes_eff;
      is_content = !line_end && !is_quote && !is_delim;
      sp         = is_space(char_byte);
   end

   assign slot_free = !valid_ff || rsp_ready;
   assign idx_nxt   = idx_ff + CW'(1);

   assign stat.slot_free   = slot_free;
   assign stat.needs_flush = is_content && !sp && (count_ff != '0);
   assign stat.flush_last  = (idx_nxt == count_ff);

   always_comb begin
      in_quotes_in = in_quotes_ff;
      pending_in   = pending_ff;
      seen_in      = seen_ff;
      count_in     = count_ff;
      idx_in       = idx_ff;
      counter_in   = counter_ff;
      ovf_in       = ovf_ff;
      hold_in      = hold_ff;
      rsp_in       = rsp_ff;
      valid_in     = valid_ff && !rsp_ready;
      ram_we       = 1'b0;
      ram_re       = 1'b0;
      ram_raddr    = '0;

      if (cmd.accept) begin
         if (line_end) begin
            rsp_in       = '{out_byte: 8'd0, byte_valid: 1'b0, field_end: 1'b1,
                             field_index: counter_ff, space_overflow: ovf_ff,
                             last_of_run: 1'b1};
            valid_in     = 1'b1;
            pending_in   = 1'b0;
            in_quotes_in = 1'b0;
            seen_in      = 1'b0;
            count_in     = '0;
            ovf_in       = 1'b0;
            counter_in   = '0;
         end else begin
            pending_in   = is_quote;
            in_quotes_in = quotes_eff;
            if (is_delim) begin
               rsp_in   = '{out_byte: 8'd0, byte_valid: 1'b0, field_end: 1'b1,
                            field_index: counter_ff, space_overflow: ovf_ff,
                            last_of_run: 1'b1};
               valid_in = 1'b1;
               seen_in  = 1'b0;
               count_in = '0;
               ovf_in   = 1'b0;
               if (counter_ff < 8'(CAP)) begin
                  counter_in = counter_ff + 8'd1;
               end
            end else if (is_content) begin
               if (sp) begin
                  // leading whitespace is dropped, inner whitespace buffered
                  if (seen_ff) begin
                     if (count_ff < CW'(SPACE_DEPTH)) begin
                        ram_we   = 1'b1;
                        count_in = count_ff + CW'(1);
                     end else begin
                        ovf_in = 1'b1;
                     end
                  end
               end else if (count_ff == '0) begin
                  rsp_in   = '{out_byte: char_byte, byte_valid: 1'b1, field_end: 1'b0,
                               field_index: counter_ff, space_overflow: 1'b0,
                               last_of_run: 1'b1};
                  valid_in = 1'b1;
                  seen_in  = 1'b1;
               end else begin
                  // flush the buffered run first; first read issued now
                  hold_in = char_byte;
                  seen_in = 1'b1;
                  idx_in  = '0;
                  ram_re  = 1'b1;
               end
            end
         end
      end

      if (cmd.flush_step) begin
         rsp_in    = '{out_byte: ram_rdata, byte_valid: 1'b1, field_end: 1'b0,
                       field_index: counter_ff, space_overflow: ovf_ff,
                       last_of_run: 1'b0};
         valid_in  = 1'b1;
         idx_in    = idx_nxt;
         ram_re    = 1'b1;
         ram_raddr = idx_nxt[AW-1:0];
      end

      if (cmd.char_emit) begin
         rsp_in   = '{out_byte: hold_ff, byte_valid: 1'b1, field_end: 1'b0,
                      field_index: counter_ff, space_overflow: 1'b0,
                      last_of_run: 1'b1};
         valid_in = 1'b1;
         count_in = '0;
         ovf_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_quotes_ff <= 1'b0;
         pending_ff   <= 1'b0;
         seen_ff      <= 1'b0;
         count_ff     <= '0;
         idx_ff       <= '0;
         counter_ff   <= '0;
         ovf_ff       <= 1'b0;
         valid_ff     <= 1'b0;
      end else begin
         in_quotes_ff <= in_quotes_in;
         pending_ff   <= pending_in;
         seen_ff      <= seen_in;
         count_ff     <= count_in;
         idx_ff       <= idx_in;
         counter_ff   <= counter_in;
         ovf_ff       <= ovf_in;
         valid_ff     <= valid_in;
      end
      hold_ff <= hold_in;
      rsp_ff  <= rsp_in;
   end

   csvft_ram #(
      .WIDTH (8),
      .DEPTH (SPACE_DEPTH)
   ) u_space_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (count_ff[AW-1:0]),
      .wdata (char_byte),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   assign rsp_valid = valid_ff;
   assign rsp       = rsp_ff;

endmodule

// ===== design/csv_field_tokenizer.sv =====
// CSV field tokenizer. Feed one line a byte per item, then a line-end item.
// Content bytes come out one per result and each field closes with a
// field-end result carrying its index (saturating). The quote character
// toggles quoted mode, a doubled quote gives one literal quote, and the
// delimiter splits fields only outside quotes. Leading whitespace of a field
// is dropped; inner whitespace runs are held in a SPACE_DEPTH-entry buffer and
// released just before the next non-space byte, or dropped at field end.
// Flow: an item causing no result or one result is taken as soon as the
// output register is empty or being drained. A byte that releases n buffered
// whitespace bytes is taken and starts the first buffer read; the n bytes and
// then the byte go out one per result, paced by the single output register
// and the buffer's registered read port, and no new item is taken meanwhile.
// Registers: delimiter at byte address 0, quote at 4 (APB, 32-bit data).
// Depends on csvft_pkg, the channel interfaces, csvft_ctrl and csvft_datapath.
`include "csv_field_tokenizer_defines.svh"

module csv_field_tokenizer
   import csvft_pkg::*;
#(
   parameter int SPACE_DEPTH = SPACE_DEPTH_DEF,
   parameter int MAX_FIELDS  = MAX_FIELDS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   csvft_req_if.sink         req_bus,
   csvft_rsp_if.source       rsp_bus,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [CSR_AW-1:0] paddr,
   input  logic [CSR_DW-1:0] pwdata,
   output logic [CSR_DW-1:0] prdata,
   output logic              pready
);

   logic [7:0]  delim_ff, delim_in;
   logic [7:0]  quote_ff, quote_in;
   logic        csr_wr;
   ctl_cmd_type cmd;
   dp_stat_type stat;
   rsp_type     rsp;

   // configuration registers
   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite;

   always_comb begin
      delim_in = delim_ff;
      quote_in = quote_ff;
      if (csr_wr) begin
         case (paddr[2])
            REG_DELIM: delim_in = pwdata[7:0];
            REG_QUOTE: quote_in = pwdata[7:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (paddr[2])
         REG_DELIM: prdata = {{(CSR_DW-8){1'b0}}, delim_ff};
         REG_QUOTE: prdata = {{(CSR_DW-8){1'b0}}, quote_ff};
         default:   prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         delim_ff <= DELIM_RESET;
         quote_ff <= QUOTE_RESET;
      end else begin
         delim_ff <= delim_in;
         quote_ff <= quote_in;
      end
   end

   csvft_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   csvft_datapath #(
      .SPACE_DEPTH (SPACE_DEPTH),
      .MAX_FIELDS  (MAX_FIELDS)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .delimiter_char (delim_ff),
      .quote_char     (quote_ff),
      .char_byte      (req_bus.char_byte),
      .line_end       (req_bus.line_end),
      .cmd            (cmd),
      .stat           (stat),
      .rsp_ready      (rsp_bus.ready),
      .rsp_valid      (rsp_bus.valid),
      .rsp            (rsp)
   );

   assign rsp_bus.out_byte       = rsp.out_byte;
   assign rsp_bus.byte_valid     = rsp.byte_valid;
   assign rsp_bus.field_end      = rsp.field_end;
   assign rsp_bus.field_index    = rsp.field_index;
   assign rsp_bus.space_overflow = rsp.space_overflow;
   assign rsp_bus.last_of_run    = rsp.last_of_run;

   // a line end always yields its field-end item straight away
   `CSVFT_ASSERT_NEXT(a_line_end_closes, clock, reset,
      cmd.accept && req_bus.line_end,
      rsp_bus.valid && rsp_bus.field_end && rsp_bus.last_of_run,
      "line end did not produce a closing field-end item")

   // the held byte must go out before another item is taken
   `CSVFT_ASSERT_NEXT(a_char_after_flush, clock, reset,
      cmd.flush_step && stat.flush_last,
      !cmd.accept,
      "item taken before the held byte of a flush was sent")

   // only flushed whitespace is not last of its run
   `CSVFT_ASSERT_NOW(a_flush_item_shape, clock, reset,
      rsp_bus.valid && !rsp_bus.last_of_run,
      rsp_bus.byte_valid && !rsp_bus.field_end,
      "non-final item is not a content byte")

   // a result without a byte can only be a field end
   `CSVFT_ASSERT_NOW(a_empty_is_field_end, clock, reset,
      rsp_bus.valid && !rsp_bus.byte_valid,
      rsp_bus.field_end && rsp_bus.last_of_run && (rsp_bus.out_byte == 8'd0),
      "byte-less item is not a final field end")

endmodule
